FILE: hw/rtl/telemetry_frame_builder_crc16_defines.svh
// ---------------------------------------------------------------------------
// Telemetry frame builder assertion macros
// Concurrent assertion wrappers on clk_i, with and without a reset guard.
// ---------------------------------------------------------------------------
`ifndef TELEMETRY_FRAME_BUILDER_CRC16_DEFINES_SVH
`define TELEMETRY_FRAME_BUILDER_CRC16_DEFINES_SVH

`ifndef SYNTH
// Checked only while rst_ni is high.
`define TFB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define TFB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define TFB_ASSERT(lbl, prop, msg)
`define TFB_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: hw/rtl/tfb_pkg.sv
// ---------------------------------------------------------------------------
// Telemetry frame builder package
// Beat types, sequencer steps and the CRC-16/CCITT-FALSE byte update.
// ---------------------------------------------------------------------------
`default_nettype none

package tfb_pkg;

  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [7:0]  NEWLINE     = 8'h0A;
  localparam logic [7:0]  MAGIC_RESET = 8'd235;

  typedef struct packed {
    logic              operation;
    logic [1:0]        tracker_type;
    logic [7:0]        tracker_number;
    logic [5:0]        app_id;
    logic [7:0]        payload_length;
    logic signed [7:0] link_rssi;
    logic signed [7:0] link_snr;
    logic [7:0]        payload_byte;
  } tfb_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_frame;
  } tfb_out_t;

  // Operation codes of an input beat.
  localparam logic OP_START   = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  // Which byte of the frame the sequencer emits next.
  typedef enum logic [3:0] {
    ST_HDR_MAGIC,
    ST_HDR_ID_LO,
    ST_HDR_ID_HI,
    ST_HDR_LEN,
    ST_PAYLOAD,
    ST_TAIL_RSSI,
    ST_TAIL_SNR,
    ST_TAIL_CRC_LO,
    ST_TAIL_CRC_HI,
    ST_TAIL_NEWLINE
  } tfb_step_e;

  // MSB-first CRC update over one byte: eight shift/xor steps on 16 bits.
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/telemetry_frame_builder_crc16.sv
// ---------------------------------------------------------------------------
// Telemetry frame builder with CRC-16 trailer
// Turns a start beat and a stream of payload beats into one framed byte
// stream: header, payload, RSSI, SNR, CRC-16/CCITT-FALSE and a newline.
// ---------------------------------------------------------------------------
// Path: an input beat is held in the input register, and each of its bytes
// then passes through the output register on its way out.
// Throughput: one byte leaves per cycle from a single-byte sequencer while
// the output is not stalled. A payload beat gives one byte, a start beat four
// (nine with an empty payload), the payload beat that ends a frame six, a dropped beat none.
// Reset: asynchronous, active low; no frame open, CRC at 0xFFFF, magic 235.
`default_nettype none

`include "telemetry_frame_builder_crc16_defines.svh"

module telemetry_frame_builder_crc16 #(
  parameter int unsigned MAX_PAYLOAD = 253
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  // Configuration: the magic byte register.
  input  wire              cfg_we_i,
  input  wire [7:0]        cfg_wdata_i,
  // Input beats.
  input  wire              in_valid_i,
  output logic             in_stall_o,
  input  tfb_pkg::tfb_in_t in_data_i,
  // Output beats, one frame byte each.
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output tfb_pkg::tfb_out_t out_data_o
);
  import tfb_pkg::*;

  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

  // Configuration register.
  logic [7:0] magic_q, magic_d;

  // Input register: the beat that the sequencer is working on, and which
  // byte of its run comes next.
  logic      item_valid_q, item_valid_d;
  tfb_in_t   item_q, item_d;
  tfb_step_e step_q, step_d;

  // Frame state carried from one beat to the next.
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_hi_q, crc_hi_d;
  logic [7:0]  bytes_left_q, bytes_left_d;
  logic [7:0]  held_rssi_q, held_rssi_d;
  logic [7:0]  held_snr_q, held_snr_d;
  logic        frame_open_q, frame_open_d;

  // Output register.
  logic     out_valid_q, out_valid_d;
  tfb_out_t out_q, out_d;

  logic        in_accept;
  logic        drop;
  logic        can_load;
  logic        fire;
  logic        run_last;
  logic        item_done;
  logic [7:0]  sel_byte;
  logic        sel_eof;
  logic [15:0] crc_base;
  logic [7:0]  clamped_len;
  logic [15:0] mission_id;
  tfb_step_e   step_next;

  // The mission id packs type, number and application id into 16 bits.
  assign mission_id  = {item_q.tracker_type, item_q.tracker_number, item_q.app_id};
  assign clamped_len = (item_q.payload_length > MaxLen) ? MaxLen : item_q.payload_length;

  // A payload beat with no frame open, or after the announced count is met,
  // leaves without producing any byte and does not wait on the output side.
  assign drop = item_valid_q && (step_q == ST_PAYLOAD) &&
                (!frame_open_q || (bytes_left_q == 8'd0));

  // The output register takes a new byte when it is empty or being drained.
  assign can_load = !out_valid_q || !out_stall_i;
  assign fire     = item_valid_q && !drop && can_load;

  // The input register frees up in the same cycle as the beat's last byte
  // moves out, so payload beats stream through one per cycle while the output is not stalled.
  assign item_done  = drop || (fire && run_last);
  assign in_stall_o = item_valid_q && !item_done;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Byte selection for the current step. The CRC restarts at the magic byte.
  always_comb begin
    sel_byte  = 8'h00;
    sel_eof   = 1'b0;
    run_last  = 1'b0;
    step_next = step_q;
    unique case (step_q)
      ST_HDR_MAGIC: begin
        sel_byte  = magic_q;
        step_next = ST_HDR_ID_LO;
      end
      ST_HDR_ID_LO: begin
        sel_byte  = mission_id[7:0];
        step_next = ST_HDR_ID_HI;
      end
      ST_HDR_ID_HI: begin
        sel_byte  = mission_id[15:8];
        step_next = ST_HDR_LEN;
      end
      ST_HDR_LEN: begin
        sel_byte = clamped_len + 8'd2;
        // An empty payload goes straight on to the tail.
        if (clamped_len == 8'd0) begin
          step_next = ST_TAIL_RSSI;
        end else begin
          run_last = 1'b1;
        end
      end
      ST_PAYLOAD: begin
        sel_byte = item_q.payload_byte;
        if (bytes_left_q == 8'd1) begin
          step_next = ST_TAIL_RSSI;
        end else begin
          run_last = 1'b1;
        end
      end
      ST_TAIL_RSSI: begin
        sel_byte  = held_rssi_q;
        step_next = ST_TAIL_SNR;
      end
      ST_TAIL_SNR: begin
        sel_byte  = held_snr_q;
        step_next = ST_TAIL_CRC_LO;
      end
      ST_TAIL_CRC_LO: begin
        sel_byte  = crc_q[7:0];
        step_next = ST_TAIL_CRC_HI;
      end
      ST_TAIL_CRC_HI: begin
        // The high byte is the one captured alongside the low byte, before
        // the low byte itself was folded into the running CRC.
        sel_byte  = crc_hi_q;
        step_next = ST_TAIL_NEWLINE;
      end
      ST_TAIL_NEWLINE: begin
        sel_byte = NEWLINE;
        sel_eof  = 1'b1;
        run_last = 1'b1;
      end
      default: begin
        sel_byte = 8'h00;
      end
    endcase
  end

  assign crc_base = (step_q == ST_HDR_MAGIC) ? CRC_INIT : crc_q;

  // Next-state logic for everything that the sequencer touches.
  always_comb begin
    magic_d      = magic_q;
    item_valid_d = item_valid_q;
    item_d       = item_q;
    step_d       = step_q;
    crc_d        = crc_q;
    crc_hi_d     = crc_hi_q;
    bytes_left_d = bytes_left_q;
    held_rssi_d  = held_rssi_q;
    held_snr_d   = held_snr_q;
    frame_open_d = frame_open_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;

    if (cfg_we_i) begin
      magic_d = cfg_wdata_i;
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (fire) begin
      out_valid_d        = 1'b1;
      out_d.out_byte     = sel_byte;
      out_d.last_of_run  = run_last;
      out_d.end_of_frame = sel_eof;
      crc_d              = crc16_feed(crc_base, sel_byte);
      step_d             = step_next;

      unique case (step_q)
        ST_HDR_MAGIC: begin
          // A start beat opens a frame, abandoning any frame left open.
          held_rssi_d  = item_q.link_rssi;
          held_snr_d   = item_q.link_snr;
          bytes_left_d = clamped_len;
          frame_open_d = 1'b1;
        end
        ST_PAYLOAD: begin
          bytes_left_d = bytes_left_q - 8'd1;
        end
        ST_TAIL_CRC_LO: begin
          crc_hi_d = crc_q[15:8];
        end
        ST_TAIL_NEWLINE: begin
          frame_open_d = 1'b0;
          bytes_left_d = 8'd0;
        end
        default: begin
          crc_hi_d = crc_hi_q;
        end
      endcase
    end

    if (item_done) begin
      item_valid_d = 1'b0;
    end

    if (in_accept) begin
      item_valid_d = 1'b1;
      item_d       = in_data_i;
      step_d       = (in_data_i.operation == OP_PAYLOAD) ? ST_PAYLOAD : ST_HDR_MAGIC;
    end
  end

  // Control and frame state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q      <= MAGIC_RESET;
      item_valid_q <= 1'b0;
      step_q       <= ST_HDR_MAGIC;
      crc_q        <= CRC_INIT;
      bytes_left_q <= 8'd0;
      held_rssi_q  <= 8'd0;
      held_snr_q   <= 8'd0;
      frame_open_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      magic_q      <= magic_d;
      item_valid_q <= item_valid_d;
      step_q       <= step_d;
      crc_q        <= crc_d;
      bytes_left_q <= bytes_left_d;
      held_rssi_q  <= held_rssi_d;
      held_snr_q   <= held_snr_d;
      frame_open_q <= frame_open_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    crc_hi_q <= crc_hi_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The newline byte always closes the run of the beat that caused it.
  `TFB_ASSERT(a_eof_is_last, out_valid_q && out_q.end_of_frame |-> out_q.last_of_run, "end of frame without last of run")
  // Emitting the newline closes the frame.
  `TFB_ASSERT(a_tail_closes, fire && (step_q == ST_TAIL_NEWLINE) |=> !frame_open_q, "frame still open after newline")
  // The remaining count never exceeds the clamp limit.
  `TFB_ASSERT(a_left_bounded, bytes_left_q <= MaxLen, "bytes_left above limit")
  // A payload beat never walks through the header steps.
  `TFB_ASSERT(a_payload_no_header, item_valid_q && (item_q.operation == OP_PAYLOAD) |-> (step_q != ST_HDR_MAGIC) && (step_q != ST_HDR_ID_LO) && (step_q != ST_HDR_ID_HI) && (step_q != ST_HDR_LEN), "payload beat in header step")
  // Nothing is dropped while a frame still expects payload bytes.
  `TFB_ASSERT(a_no_bad_drop, drop |-> !frame_open_q || (bytes_left_q == 8'd0), "payload beat dropped inside open frame")

endmodule

`default_nettype wire

FILE: dv/tfb_frame_checker.sv
// ---------------------------------------------------------------------------
// Telemetry frame byte checker
// Watches the beat channels of the frame builder, works out every frame
// byte that each accepted input beat should produce and compares the output
// beats against that prediction in order.
// ---------------------------------------------------------------------------
module tfb_frame_checker #(
  parameter int unsigned MAX_PAYLOAD = 253
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_we_i,
  input  wire [7:0]         cfg_wdata_i,
  input  wire               in_valid_i,
  input  wire               in_stall_i,
  input  tfb_pkg::tfb_in_t  in_data_i,
  input  wire               out_valid_i,
  input  wire               out_stall_i,
  input  tfb_pkg::tfb_out_t out_data_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       checked_o,
  output int unsigned       frames_o
);
  import tfb_pkg::*;

  // Shadow of the block's frame state.
  logic [7:0]  magic_q;
  logic [15:0] crc_acc;
  logic [7:0]  left_cnt;
  logic [7:0]  rssi_hold;
  logic [7:0]  snr_hold;
  logic        open_frame;

  tfb_out_t    run_q[$];
  tfb_out_t    frame_bytes_q[$];
  int unsigned fails;
  int unsigned checked;
  int unsigned frames;

  // CRC-16/CCITT-FALSE, one data bit at a time, MSB first.
  function automatic logic [15:0] crc_after(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ data[i];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  task automatic emit_byte(input logic [7:0] v, input logic eof);
    tfb_out_t ob;
    ob.out_byte     = v;
    ob.last_of_run  = 1'b0;
    ob.end_of_frame = eof;
    run_q.push_back(ob);
    crc_acc = crc_after(crc_acc, v);
  endtask

  // The CRC covers everything up to and including SNR.
  task automatic emit_tail();
    logic [15:0] crc_snap;
    emit_byte(rssi_hold, 1'b0);
    emit_byte(snr_hold, 1'b0);
    crc_snap = crc_acc;
    emit_byte(crc_snap[7:0], 1'b0);
    emit_byte(crc_snap[15:8], 1'b0);
    emit_byte(NEWLINE, 1'b1);
    open_frame = 1'b0;
    left_cnt   = '0;
  endtask

  task automatic predict_frame_bytes(input tfb_in_t b);
    logic [7:0]  len;
    logic [15:0] mission;
    tfb_out_t    closing;
    run_q.delete();
    if (b.operation == OP_START) begin
      len        = (b.payload_length > MAX_PAYLOAD) ? 8'(MAX_PAYLOAD) : b.payload_length;
      mission    = {b.tracker_type, b.tracker_number, b.app_id};
      rssi_hold  = b.link_rssi;
      snr_hold   = b.link_snr;
      crc_acc    = CRC_INIT;
      left_cnt   = len;
      open_frame = 1'b1;
      emit_byte(magic_q, 1'b0);
      emit_byte(mission[7:0], 1'b0);
      emit_byte(mission[15:8], 1'b0);
      emit_byte(8'(len + 8'd2), 1'b0);
      if (left_cnt == 0) begin
        emit_tail();
      end
    end else if (open_frame && left_cnt != 0) begin
      emit_byte(b.payload_byte, 1'b0);
      left_cnt = left_cnt - 8'd1;
      if (left_cnt == 0) begin
        emit_tail();
      end
    end
    if (run_q.size() != 0) begin
      closing = run_q.pop_back();
      closing.last_of_run = 1'b1;
      run_q.push_back(closing);
      foreach (run_q[i]) begin
        frame_bytes_q.push_back(run_q[i]);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tfb_out_t want;
    if (!rst_ni) begin
      magic_q    = MAGIC_RESET;
      crc_acc    = CRC_INIT;
      left_cnt   = '0;
      rssi_hold  = '0;
      snr_hold   = '0;
      open_frame = 1'b0;
      frame_bytes_q.delete();
      fails   = 0;
      checked = 0;
      frames  = 0;
    end else begin
      if (cfg_we_i) begin
        magic_q = cfg_wdata_i;
      end
      // A byte can never leave on the edge that accepts its own beat, so
      // comparing first keeps the queue order right.
      if (out_valid_i && !out_stall_i) begin
        if (frame_bytes_q.size() == 0) begin
          $error("frame byte %02h arrived with nothing expected", out_data_i.out_byte);
          fails++;
        end else begin
          want = frame_bytes_q.pop_front();
          checked++;
          if (out_data_i.out_byte !== want.out_byte) begin
            $error("out_byte mismatch: expected %02h, got %02h",
                   want.out_byte, out_data_i.out_byte);
            fails++;
          end
          if (out_data_i.last_of_run !== want.last_of_run) begin
            $error("last_of_run mismatch: expected %0b, got %0b",
                   want.last_of_run, out_data_i.last_of_run);
            fails++;
          end
          if (out_data_i.end_of_frame !== want.end_of_frame) begin
            $error("end_of_frame mismatch: expected %0b, got %0b",
                   want.end_of_frame, out_data_i.end_of_frame);
            fails++;
          end
          if (want.end_of_frame) begin
            frames++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_frame_bytes(in_data_i);
      end
    end
    fail_count_o <= fails;
    pending_o    <= frame_bytes_q.size();
    checked_o    <= checked;
    frames_o     <= frames;
  end

endmodule

FILE: dv/telemetry_frame_builder_crc16_test.sv
// ---------------------------------------------------------------------------
// Telemetry frame builder regression
// Drives start and payload beats into the frame builder under changing
// handshake pressure and magic byte settings; a checker beside the block
// predicts every frame byte and counts mismatches for the verdict here.
// ---------------------------------------------------------------------------
module telemetry_frame_builder_crc16_test;
  import tfb_pkg::*;

  localparam int unsigned MAX_PAYLOAD     = 253;
  // Longest run with no beat moving on either side before we give up. The
  // worst correct case is the receiver hold-off plus a phase drain.
  localparam int unsigned WATCHDOG_LIMIT  = 3000;
  // Covers a full nine-byte run through the input and output registers, with some
  // margin, so a dropped beat still in flight has settled before a register write.
  localparam int unsigned DRAIN_CYCLES    = 16;
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned RANDOM_ITEMS    = 60;

  // Every input of the block starts at a known value.
  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [7:0]  cfg_wdata_i = 8'h00;
  logic        in_valid_i  = 1'b0;
  tfb_in_t     in_data_i   = '0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  tfb_out_t    out_data_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned bytes_checked;
  int unsigned frames_closed;

  // Handshake pressure, in percent of cycles spent idle on each side.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  // Beats that actually build frames; dropped beats are left out.
  int unsigned items_sent    = 0;
  int unsigned quiet_cycles  = 0;
  logic [7:0]  last_magic;
  logic        holding_off   = 1'b0;
  event        hold_off_ev;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  telemetry_frame_builder_crc16 #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  tfb_frame_checker #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (bytes_checked),
    .frames_o    (frames_closed)
  );

  // Receiver side. Normally it stalls at random; during a hold-off it stalls
  // solidly so the block backs up and has to stall its own input.
  always @(posedge clk_i) begin
    if (holding_off) begin
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // The hold-off length is counted here, independent of the sender.
  initial begin
    forever begin
      @(hold_off_ev);
      holding_off <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      holding_off <= 1'b0;
    end
  end

  // The watchdog restarts whenever a beat moves on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("telemetry_frame_builder_crc16 regression: fail");
      $finish;
    end
  end

  // Fields that do not belong to a beat's operation are filled at random,
  // since the block has to ignore them.
  function automatic tfb_in_t noise_beat();
    logic [63:0] r;
    tfb_in_t     b;
    r = {$urandom, $urandom};
    b = r[$bits(tfb_in_t)-1:0];
    return b;
  endfunction

  function automatic tfb_in_t start_beat(input logic [1:0] kind, input logic [7:0] num,
                                         input logic [5:0] app, input logic [7:0] len,
                                         input logic [7:0] rssi, input logic [7:0] snr);
    tfb_in_t b;
    b                = noise_beat();
    b.operation      = OP_START;
    b.tracker_type   = kind;
    b.tracker_number = num;
    b.app_id         = app;
    b.payload_length = len;
    b.link_rssi      = rssi;
    b.link_snr       = snr;
    return b;
  endfunction

  function automatic tfb_in_t payload_beat(input logic [7:0] v);
    tfb_in_t b;
    b              = noise_beat();
    b.operation    = OP_PAYLOAD;
    b.payload_byte = v;
    return b;
  endfunction

  // Offers one beat and returns on the edge that accepts it. Valid is left
  // high on purpose: the next call either idles or offers the next beat in
  // the same time step, so valid only ever gets one update per step.
  task automatic send_beat(input tfb_in_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
  endtask

  // Stops offering, waits for every predicted byte to come out, then lets
  // the pipeline settle in case a dropped beat is still travelling.
  task automatic quiesce();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_magic(input logic [7:0] v);
    quiesce();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly well-formed frames with random content. Some frames are cut
  // short and abandoned by the next start, and some complete frames are
  // followed by surplus bytes that the block must drop. Lengths are mostly
  // small; a few are large, and those are always abandoned early.
  task automatic run_random(input int unsigned target);
    int unsigned goal;
    int unsigned len;
    int unsigned eff;
    int unsigned n_pay;
    int unsigned roll;
    goal = items_sent + target;
    while (items_sent < goal) begin
      roll = $urandom_range(99);
      if (roll < 70) begin
        len = $urandom_range(12);
      end else if (roll < 88) begin
        len = $urandom_range(40, 13);
      end else begin
        len = $urandom_range(255, 41);
      end
      eff = (len > MAX_PAYLOAD) ? MAX_PAYLOAD : len;
      if (len > 40 || $urandom_range(99) < 12) begin
        n_pay = $urandom_range((eff < 6) ? eff : 6);
      end else begin
        n_pay = eff;
      end
      send_beat(start_beat(2'($urandom), 8'($urandom), 6'($urandom), 8'(len),
                           8'($urandom), 8'($urandom)));
      repeat (n_pay) send_beat(payload_beat(8'($urandom)));
      items_sent += 1 + n_pay;
      if (n_pay == eff && $urandom_range(99) < 20) begin
        repeat ($urandom_range(2, 1)) send_beat(payload_beat(8'($urandom)));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phase one: a lazy sender and a busy receiver, magic at its reset value.
    send_idle_pct = 21;
    recv_idle_pct = 54;

    // A payload beat with no frame open must be dropped.
    send_beat(payload_beat(8'h5A));
    // Empty payloads give header and tail in one run; all-ones and all-zeros
    // ids, and the signed extremes of RSSI and SNR.
    send_beat(start_beat(2'd3, 8'hFF, 6'h3F, 8'd0, 8'h80, 8'h7F));
    send_beat(start_beat(2'd0, 8'h00, 6'h00, 8'd0, 8'h7F, 8'h80));
    // A one-byte frame, then a surplus byte that must be dropped.
    send_beat(start_beat(2'd1, 8'h01, 6'h01, 8'd1, 8'hFF, 8'h00));
    send_beat(payload_beat(8'hFF));
    send_beat(payload_beat(8'h00));
    // The largest length is cut to the maximum, and the frame is then
    // abandoned by a new start that runs to completion.
    send_beat(start_beat(2'd2, 8'hA5, 6'h2A, 8'd255, 8'h01, 8'hFE));
    send_beat(payload_beat(8'h00));
    send_beat(payload_beat(8'hFF));
    send_beat(start_beat(2'd1, 8'h5A, 6'h15, 8'd2, 8'hC0, 8'h3F));
    send_beat(payload_beat(8'h5A));
    send_beat(payload_beat(8'hA5));
    // Exactly the maximum and one past it, each abandoned, then a short
    // frame that closes normally.
    send_beat(start_beat(2'd3, 8'h80, 6'h20, 8'd253, 8'h00, 8'hFF));
    send_beat(payload_beat(8'h0F));
    send_beat(start_beat(2'd2, 8'h7F, 6'h10, 8'd254, 8'h55, 8'hAA));
    send_beat(payload_beat(8'hF0));
    send_beat(start_beat(2'd0, 8'hC3, 6'h07, 8'd3, 8'hAA, 8'h55));
    repeat (3) send_beat(payload_beat(8'($urandom)));
    items_sent += 18;

    write_magic(8'h00);
    run_random(RANDOM_ITEMS);

    // Phase two: the roles swap, with the magic byte at all ones.
    send_idle_pct = 54;
    recv_idle_pct = 21;
    write_magic(8'hFF);
    run_random(RANDOM_ITEMS);

    // Phase three: no idling at all, a random magic byte, and a long
    // receiver hold-off at the start while the sender keeps offering.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    last_magic    = 8'($urandom_range(254, 1));
    write_magic(last_magic);
    -> hold_off_ev;
    run_random(RANDOM_ITEMS);

    quiesce();
    $display("Ran %0d frame-building beats over three handshake patterns, magic 235, 0x00,",
             items_sent);
    $display("0xFF and 0x%02h: %0d frame bytes checked, %0d frames closed.",
             last_magic, bytes_checked, frames_closed);
    if (fail_count == 0 && pending == 0) begin
      $display("telemetry_frame_builder_crc16 regression: pass");
    end else begin
      $display("telemetry_frame_builder_crc16 regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/tfb_pkg.sv
hw/rtl/telemetry_frame_builder_crc16.sv
dv/tfb_frame_checker.sv
dv/telemetry_frame_builder_crc16_test.sv
